[design/assert_macros.svh]
// assertion helpers used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/i2cm_pkg.sv]
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4
    } t_cmd;

    localparam logic [15:0] PHASE_RESET  = 16'd80;
    localparam logic [4:0]  SHORT_PHASES = 5'd3;
    localparam logic [4:0]  BYTE_PHASES  = 5'd27;
    localparam logic [4:0]  ACK_PHASE    = 5'd24;

    typedef struct packed {
        t_cmd        op;
        logic [4:0]  phase;
        logic [15:0] cnt;
        logic [7:0]  shift;
        logic        ack_choice;
        logic        scl;
        logic        sda;
        logic [7:0]  rx_byte;
        logic        ack_flag;
    } t_eng_state;

    localparam t_eng_state ENG_RESET = '{
        op:         CMD_NONE,
        phase:      5'd0,
        cnt:        16'd0,
        shift:      8'd0,
        ack_choice: 1'b0,
        scl:        1'b1,
        sda:        1'b1,
        rx_byte:    8'd0,
        ack_flag:   1'b0
    };

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_seen;
    } t_result;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_sample;
    } t_in_beat;

endpackage

[design/i2cm_step.sv]
// ----------------------------------------------------------------------------
// i2cm_step
// One clock tick of the bus sequencer: command start, phase count, SDA
// sampling and drive update, as next-state logic.
// ----------------------------------------------------------------------------
module i2cm_step (
    input  i2cm_pkg::t_eng_state cur,
    input  i2cm_pkg::t_in_beat   beat,
    input  logic [15:0]          phase_cycles,
    output i2cm_pkg::t_eng_state nxt,
    output i2cm_pkg::t_result    res
);
    import i2cm_pkg::*;

    // divide by three through reciprocal multiply, exact for five-bit values
    function automatic logic [3:0] div3(input logic [4:0] p);
        logic [9:0] prod;
        prod = {5'd0, p} * 10'd11;
        return prod[8:5];
    endfunction

    function automatic logic [1:0] mod3(input logic [4:0] p);
        logic [5:0] tri3;
        logic [5:0] diff;
        tri3 = {2'd0, div3(p)} * 6'd3;
        diff = {1'b0, p} - tri3;
        return diff[1:0];
    endfunction

    // drives {scl, sda} at the start of phase p
    function automatic logic [1:0] enter_phase(
        input t_cmd       op,
        input logic [4:0] p,
        input logic [7:0] shift,
        input logic       ack_choice,
        input logic       scl_in,
        input logic       sda_in
    );
        logic       scl;
        logic       sda;
        logic [1:0] r;
        logic [3:0] q;
        scl = scl_in;
        sda = sda_in;
        r   = mod3(p);
        q   = div3(p);
        unique case (op)
            CMD_START: begin
                priority if (p == 5'd0) begin
                    sda = 1'b1;
                    scl = 1'b1;
                end else if (p == 5'd1) begin
                    sda = 1'b0;
                end else begin
                    scl = 1'b0;
                end
            end
            CMD_STOP: begin
                priority if (p == 5'd0) begin
                    sda = 1'b0;
                end else if (p == 5'd1) begin
                    scl = 1'b1;
                end else begin
                    sda = 1'b1;
                end
            end
            CMD_WRITE: begin
                priority if (p < ACK_PHASE) begin
                    priority if (r == 2'd0) begin
                        sda = shift[~q[2:0]];
                    end else if (r == 2'd1) begin
                        scl = 1'b1;
                    end else begin
                        scl = 1'b0;
                    end
                end else if (p == ACK_PHASE) begin
                    sda = 1'b1;
                end else if (p == ACK_PHASE + 5'd1) begin
                    scl = 1'b1;
                end else begin
                    scl = 1'b0;
                end
            end
            CMD_READ: begin
                priority if (p < ACK_PHASE) begin
                    priority if (p == 5'd0) begin
                        sda = 1'b1;
                    end else if (r == 2'd1) begin
                        scl = 1'b1;
                    end else if (r == 2'd2) begin
                        scl = 1'b0;
                    end else begin
                        // later bit-start phases keep both drives
                    end
                end else if (p == ACK_PHASE) begin
                    sda = !ack_choice;
                end else if (p == ACK_PHASE + 5'd1) begin
                    scl = 1'b1;
                end else begin
                    scl = 1'b0;
                    sda = 1'b1;
                end
            end
            default: begin
            end
        endcase
        return {scl, sda};
    endfunction

    t_cmd        cmd;
    logic [15:0] len;
    logic [16:0] cnt_inc;
    logic [4:0]  ph_next;
    logic [4:0]  total;
    logic        done;

    assign cmd = t_cmd'(beat.command);
    assign len = (phase_cycles == 16'd0) ? 16'd1 : phase_cycles;

    always_comb begin
        nxt     = cur;
        done    = 1'b0;
        cnt_inc = 17'd0;
        ph_next = 5'd0;
        total   = BYTE_PHASES;

        if (cur.op == CMD_NONE && (cmd == CMD_START || cmd == CMD_STOP ||
                                   cmd == CMD_WRITE || cmd == CMD_READ)) begin
            nxt.op         = cmd;
            nxt.phase      = 5'd0;
            nxt.cnt        = 16'd0;
            nxt.shift      = (cmd == CMD_WRITE) ? beat.tx_byte : 8'd0;
            nxt.ack_choice = beat.send_ack;
            {nxt.scl, nxt.sda} = enter_phase(cmd, 5'd0, nxt.shift, beat.send_ack,
                                             cur.scl, cur.sda);
        end

        if (nxt.op != CMD_NONE) begin
            total   = (nxt.op == CMD_START || nxt.op == CMD_STOP) ? SHORT_PHASES
                                                                  : BYTE_PHASES;
            cnt_inc = {1'b0, nxt.cnt} + 17'd1;
            if (cnt_inc >= {1'b0, len}) begin
                // sample at the end of an scl-high phase
                if (nxt.op == CMD_WRITE && nxt.phase == ACK_PHASE + 5'd1) begin
                    nxt.ack_flag = !beat.sda_sample;
                end else if (nxt.op == CMD_READ && nxt.phase < ACK_PHASE &&
                             mod3(nxt.phase) == 2'd1) begin
                    nxt.shift = {nxt.shift[6:0], beat.sda_sample};
                end
                ph_next = nxt.phase + 5'd1;
                nxt.cnt = 16'd0;
                if (ph_next >= total) begin
                    if (nxt.op == CMD_READ) begin
                        nxt.rx_byte = nxt.shift;
                    end
                    nxt.op    = CMD_NONE;
                    nxt.phase = 5'd0;
                    done      = 1'b1;
                end else begin
                    nxt.phase = ph_next;
                    {nxt.scl, nxt.sda} = enter_phase(nxt.op, ph_next, nxt.shift,
                                                     nxt.ack_choice, nxt.scl, nxt.sda);
                end
            end else begin
                nxt.cnt = cnt_inc[15:0];
            end
        end
    end

    assign res.scl_level = nxt.scl;
    assign res.sda_level = nxt.sda;
    assign res.busy_res  = (nxt.op != CMD_NONE);
    assign res.done_res  = done;
    assign res.rx_byte   = nxt.rx_byte;
    assign res.ack_seen  = nxt.ack_flag;

endmodule

[design/i2c_master_byte_engine_top.sv]
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_top
// I2C master byte engine: one input beat is one tick of the bus sequencer.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry one tick with a command
// (none, start, stop, write byte, read byte), tx byte, ack choice and the
// sensed SDA level. Output channel: o_out_valid / i_out_stall carry one
// result beat per input beat with the SCL/SDA drives, busy, done pulse,
// received byte and seen acknowledge.
// Path: an accepted beat lands in the input register and is processed
// from there into the result register, which offers its result.
// Throughput: one beat per cycle while the receiver does not stall; the
// sequencer state updates combinationally between the input register and
// the result register.
// Stall: while the result register holds a beat that the receiver stalls,
// the input register holds too and o_in_stall rises once it is full.
// Reset (i_rst_n low, synchronous): both registers empty, engine idle with
// SCL and SDA released, phase length back to 80.
// i_cfg_we writes the phase length; write it only while the engine is idle.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_command,
    input  logic [7:0]  i_tx_byte,
    input  logic        i_send_ack,
    input  logic        i_sda_sample,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_scl_level,
    output logic        o_sda_level,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic [7:0]  o_rx_byte,
    output logic        o_ack_seen
);
    import i2cm_pkg::*;

    logic        r_in_valid;
    t_in_beat    r_in_beat;
    logic        r_out_valid;
    t_result     r_out;
    t_eng_state  r_state;
    logic [15:0] r_phase_cycles;

    t_eng_state  n_state;
    t_result     n_out;
    logic        out_free;
    logic        advance;
    logic        in_take;

    assign out_free = !r_out_valid || !i_out_stall;
    assign advance  = r_in_valid && out_free;
    assign in_take  = i_in_valid && !o_in_stall;

    assign o_in_stall = r_in_valid && !out_free;

    i2cm_step u_step (
        .cur          (r_state),
        .beat         (r_in_beat),
        .phase_cycles (r_phase_cycles),
        .nxt          (n_state),
        .res          (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_cycles <= PHASE_RESET;
        end else if (i_cfg_we) begin
            r_phase_cycles <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_beat <= '{command: i_command, tx_byte: i_tx_byte,
                           send_ack: i_send_ack, sda_sample: i_sda_sample};
        end
    end

    // sequencer state moves once per processed beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ENG_RESET;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_scl_level = r_out.scl_level;
    assign o_sda_level = r_out.sda_level;
    assign o_busy_res  = r_out.busy_res;
    assign o_done_res  = r_out.done_res;
    assign o_rx_byte   = r_out.rx_byte;
    assign o_ack_seen  = r_out.ack_seen;

endmodule

[design/i2cm_checker.sv]
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks of the I2C master byte engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2cm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_busy_res,
    input logic       o_done_res,
    input logic [7:0] o_rx_byte,
    input logic       o_ack_seen
);

    // a stalled result beat holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
                 o_out_valid && $stable(o_rx_byte) && $stable(o_ack_seen))

    // a finishing beat already shows the engine idle
    `ASSERT_IMPL(a_done_idle, i_clk, i_rst_n, o_out_valid && o_done_res, !o_busy_res)

    // the input side only backs up behind a held result beat
    `ASSERT_IMPL(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)

    // nothing is offered right after reset
    `ASSERT_IMPL(a_reset_empty, i_clk, i_rst_n, $past(!i_rst_n), !o_out_valid)

endmodule

bind i2c_master_byte_engine_top i2cm_checker u_i2cm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_busy_res  (o_busy_res),
    .o_done_res  (o_done_res),
    .o_rx_byte   (o_rx_byte),
    .o_ack_seen  (o_ack_seen)
);

[tb/i2c_master_byte_engine_checker.sv]
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_checker
// Watches both channels of the byte engine, runs a cycle model of the bus
// sequencer on every accepted input beat and compares each result beat
// against the oldest predicted one.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [2:0]  i_command,
    input  logic [7:0]  i_tx_byte,
    input  logic        i_send_ack,
    input  logic        i_sda_sample,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_scl_level,
    input  logic        i_sda_level,
    input  logic        i_busy_res,
    input  logic        i_done_res,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_ack_seen,
    output int          o_mismatch_count,
    output int          o_beats_in_flight
);
    import i2cm_pkg::*;

    logic [15:0] phase_len;
    t_cmd        op;
    logic [4:0]  phase;
    int unsigned ticks_in_phase;
    logic [7:0]  shift_q;
    logic        ack_sel;
    logic        scl_q;
    logic        sda_q;
    logic [7:0]  rx_q;
    logic        ack_q;
    t_result     pending_results[$];

    function automatic void reset_model();
        phase_len      = PHASE_RESET;
        op             = CMD_NONE;
        phase          = '0;
        ticks_in_phase = 0;
        shift_q        = '0;
        ack_sel        = 1'b0;
        scl_q          = 1'b1;
        sda_q          = 1'b1;
        rx_q           = '0;
        ack_q          = 1'b0;
    endfunction

    // line drives that take effect when phase p begins
    function automatic void set_phase_drives(logic [4:0] p);
        int pi;
        int slot;
        pi   = p;
        slot = pi % 3;
        case (op)
            CMD_START: begin
                if (pi == 0) begin
                    scl_q = 1'b1;
                    sda_q = 1'b1;
                end else if (pi == 1) begin
                    sda_q = 1'b0;
                end else begin
                    scl_q = 1'b0;
                end
            end
            CMD_STOP: begin
                if (pi == 0) begin
                    sda_q = 1'b0;
                end else if (pi == 1) begin
                    scl_q = 1'b1;
                end else begin
                    sda_q = 1'b1;
                end
            end
            CMD_WRITE: begin
                if (pi < ACK_PHASE) begin
                    if (slot == 0) begin
                        sda_q = shift_q[7 - pi / 3];
                    end else if (slot == 1) begin
                        scl_q = 1'b1;
                    end else begin
                        scl_q = 1'b0;
                    end
                end else if (pi == ACK_PHASE) begin
                    sda_q = 1'b1;
                end else if (pi == ACK_PHASE + 1) begin
                    scl_q = 1'b1;
                end else begin
                    scl_q = 1'b0;
                end
            end
            CMD_READ: begin
                if (pi < ACK_PHASE) begin
                    if (pi == 0) begin
                        sda_q = 1'b1;
                    end else if (slot == 1) begin
                        scl_q = 1'b1;
                    end else if (slot == 2) begin
                        scl_q = 1'b0;
                    end
                end else if (pi == ACK_PHASE) begin
                    sda_q = ~ack_sel;
                end else if (pi == ACK_PHASE + 1) begin
                    scl_q = 1'b1;
                end else begin
                    scl_q = 1'b0;
                    sda_q = 1'b1;
                end
            end
            default: ;
        endcase
    endfunction

    // one sequencer tick: returns the result beat it produces
    function automatic t_result bus_tick(logic [2:0] cmd, logic [7:0] tx, logic sack,
                                         logic sda);
        int unsigned len;
        int unsigned total;
        logic        fin;
        t_result     r;
        len = (phase_len == 16'd0) ? 1 : phase_len;
        fin = 1'b0;
        if (op == CMD_NONE && cmd >= CMD_START && cmd <= CMD_READ) begin
            op             = t_cmd'(cmd);
            phase          = '0;
            ticks_in_phase = 0;
            shift_q        = (cmd == CMD_WRITE) ? tx : 8'd0;
            ack_sel        = sack;
            set_phase_drives(5'd0);
        end
        if (op != CMD_NONE) begin
            ticks_in_phase++;
            if (ticks_in_phase >= len) begin
                // sda is taken at the end of a scl-high phase
                if (op == CMD_WRITE && phase == ACK_PHASE + 1) begin
                    ack_q = ~sda;
                end else if (op == CMD_READ && phase < ACK_PHASE && phase % 3 == 1) begin
                    shift_q = {shift_q[6:0], sda};
                end
                phase++;
                ticks_in_phase = 0;
                total = (op == CMD_START || op == CMD_STOP) ? SHORT_PHASES : BYTE_PHASES;
                if (phase >= total) begin
                    if (op == CMD_READ) begin
                        rx_q = shift_q;
                    end
                    op    = CMD_NONE;
                    phase = '0;
                    fin   = 1'b1;
                end else begin
                    set_phase_drives(phase);
                end
            end
        end
        r.scl_level = scl_q;
        r.sda_level = sda_q;
        r.busy_res  = (op != CMD_NONE);
        r.done_res  = fin;
        r.rx_byte   = rx_q;
        r.ack_seen  = ack_q;
        return r;
    endfunction

    function automatic void report_mismatch(string why, t_result want, t_result seen);
        o_mismatch_count++;
        if (o_mismatch_count <= 10) begin
            $write("%0t: %s: expected scl=%b sda=%b busy=%b done=%b rx=%02h ack=%b, ",
                   $time, why,
                   want.scl_level, want.sda_level, want.busy_res, want.done_res,
                   want.rx_byte, want.ack_seen);
            $display("got scl=%b sda=%b busy=%b done=%b rx=%02h ack=%b",
                     seen.scl_level, seen.sda_level, seen.busy_res, seen.done_res,
                     seen.rx_byte, seen.ack_seen);
        end
    endfunction

    always @(posedge i_clk) begin
        t_result seen;
        t_result want;
        if (!i_rst_n) begin
            reset_model();
            pending_results.delete();
            o_mismatch_count = 0;
        end else begin
            if (i_cfg_we) begin
                phase_len = i_cfg_data;
            end
            if (i_out_valid && !i_out_stall) begin
                seen = '{i_scl_level, i_sda_level, i_busy_res, i_done_res, i_rx_byte,
                         i_ack_seen};
                if (pending_results.size() == 0) begin
                    report_mismatch("result beat with nothing expected", '0, seen);
                end else begin
                    want = pending_results.pop_front();
                    if (seen !== want) begin
                        report_mismatch("result beat mismatch", want, seen);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                pending_results.push_back(bus_tick(i_command, i_tx_byte, i_send_ack,
                                                   i_sda_sample));
            end
        end
        o_beats_in_flight = pending_results.size();
    end

endmodule

[tb/tb_i2c_master_byte_engine_top.sv]
// ----------------------------------------------------------------------------
// tb_i2c_master_byte_engine_top
// Drives start, stop, byte write and byte read sequences into the byte
// engine under several phase lengths, with bursty input and a stalling
// receiver; the checker beside the engine predicts and compares every beat.
// ----------------------------------------------------------------------------
module tb_i2c_master_byte_engine_top;
    import i2cm_pkg::*;

    localparam int SDA_RANDOM = 0;
    localparam int SDA_LOW    = 1;
    localparam int SDA_HIGH   = 2;

    localparam int STALL_NONE     = 0;
    localparam int STALL_LIGHT    = 1;
    localparam int STALL_HEAVY    = 2;
    localparam int STALL_PERIODIC = 3;

    // command codes with no meaning to the engine
    localparam logic [2:0] CMD_RSVD_FIRST = 3'd5;
    localparam logic [2:0] CMD_RSVD_LAST  = 3'd7;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_cfg_we     = 1'b0;
    logic [15:0] i_cfg_data   = '0;
    logic        i_in_valid   = 1'b0;
    logic [2:0]  i_command    = CMD_NONE;
    logic [7:0]  i_tx_byte    = '0;
    logic        i_send_ack   = 1'b0;
    logic        i_sda_sample = 1'b1;
    logic        i_out_stall  = 1'b0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_scl_level;
    logic        o_sda_level;
    logic        o_busy_res;
    logic        o_done_res;
    logic [7:0]  o_rx_byte;
    logic        o_ack_seen;

    int          mismatch_count;
    int          beats_in_flight;

    int unsigned bus_phase_len = PHASE_RESET;
    int          gap_max       = 3;
    int          burst_left    = 0;
    int          cmds_issued   = 0;
    int          stall_mode    = STALL_NONE;
    int          stall_left    = 0;

    always #5 i_clk = ~i_clk;

    i2c_master_byte_engine_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_tx_byte    (i_tx_byte),
        .i_send_ack   (i_send_ack),
        .i_sda_sample (i_sda_sample),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_scl_level  (o_scl_level),
        .o_sda_level  (o_sda_level),
        .o_busy_res   (o_busy_res),
        .o_done_res   (o_done_res),
        .o_rx_byte    (o_rx_byte),
        .o_ack_seen   (o_ack_seen)
    );

    i2c_master_byte_engine_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_command         (i_command),
        .i_tx_byte         (i_tx_byte),
        .i_send_ack        (i_send_ack),
        .i_sda_sample      (i_sda_sample),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_scl_level       (o_scl_level),
        .i_sda_level       (o_sda_level),
        .i_busy_res        (o_busy_res),
        .i_done_res        (o_done_res),
        .i_rx_byte         (o_rx_byte),
        .i_ack_seen        (o_ack_seen),
        .o_mismatch_count  (mismatch_count),
        .o_beats_in_flight (beats_in_flight)
    );

    // receiver: stall pattern is picked anew each time its countdown runs out
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(STALL_NONE, STALL_PERIODIC);
            stall_left = $urandom_range(16, 400);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            STALL_NONE:  i_out_stall <= 1'b0;
            STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_out_stall <= ($urandom_range(0, 9) < 7);
            default:     i_out_stall <= (stall_left % 3 == 0);
        endcase
    end

    function automatic logic sda_for(int mode);
        case (mode)
            SDA_LOW:  return 1'b0;
            SDA_HIGH: return 1'b1;
            default:  return 1'($urandom_range(0, 1));
        endcase
    endfunction

    // one beat, held until taken; bursts separated by random gaps
    task automatic send_tick(logic [2:0] cmd, logic [7:0] tx, logic sack, logic sda);
        bit took;
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_tx_byte    <= tx;
        i_send_ack   <= sack;
        i_sda_sample <= sda;
        do begin
            @(negedge i_clk);
            took = !o_in_stall;
            @(posedge i_clk);
        end while (!took);
        burst_left--;
    endtask

    // a command beat followed by exactly enough ticks for the engine to finish it
    task automatic issue(logic [2:0] cmd, logic [7:0] tx, logic sack, int sda_mode,
                         int noise_pct);
        int len;
        int ticks;
        len = (bus_phase_len == 0) ? 1 : int'(bus_phase_len);
        if (cmd == CMD_START || cmd == CMD_STOP) begin
            ticks = SHORT_PHASES * len;
        end else if (cmd == CMD_WRITE || cmd == CMD_READ) begin
            ticks = BYTE_PHASES * len;
        end else begin
            ticks = 1;
        end
        send_tick(cmd, tx, sack, sda_for(sda_mode));
        for (int k = 1; k < ticks; k++) begin
            send_tick(($urandom_range(0, 99) < noise_pct) ? 3'($urandom_range(0, 7))
                                                          : CMD_NONE,
                      8'($urandom), 1'($urandom), sda_for(sda_mode));
        end
        cmds_issued++;
    endtask

    task automatic run_transaction(int noise_pct);
        int nbytes;
        int mode;
        if ($urandom_range(0, 99) < 85) begin
            issue(CMD_START, 8'($urandom), 1'($urandom), SDA_RANDOM, noise_pct);
            nbytes = $urandom_range(1, 4);
            repeat (nbytes) begin
                mode = ($urandom_range(0, 9) < 7) ? SDA_RANDOM
                                                  : $urandom_range(SDA_LOW, SDA_HIGH);
                if ($urandom_range(0, 1)) begin
                    issue(CMD_WRITE, 8'($urandom), 1'($urandom), mode, noise_pct);
                end else begin
                    issue(CMD_READ, 8'($urandom), 1'($urandom), mode, noise_pct);
                end
            end
            issue(CMD_STOP, 8'($urandom), 1'($urandom), SDA_RANDOM, noise_pct);
        end else begin
            // stray command outside any well-formed transfer
            issue(3'($urandom_range(CMD_NONE, CMD_RSVD_LAST)), 8'($urandom), 1'($urandom),
                  SDA_RANDOM, noise_pct);
        end
        repeat ($urandom_range(0, 2)) begin
            send_tick($urandom_range(0, 1) ? CMD_NONE
                                           : 3'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST)),
                      8'($urandom), 1'($urandom), 1'($urandom));
        end
    endtask

    // hold off the sender until every result beat is back, plus pipeline slack
    task automatic drain_results();
        i_in_valid <= 1'b0;
        burst_left = 0;
        @(negedge i_clk);
        while (beats_in_flight != 0) @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_phase_len(logic [15:0] value);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        bus_phase_len = value;
    endtask

    initial begin
        int unsigned phase_lens[7];
        int          target;
        phase_lens = '{1, 2, 1, 0, 3, 1, 2};
        phase_lens[5] = $urandom_range(1, 3);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset phase length: idle codes and one short command
        gap_max = 2;
        issue(CMD_NONE, 8'hFF, 1'b1, SDA_RANDOM, 0);
        for (int c = CMD_RSVD_FIRST; c <= CMD_RSVD_LAST; c++) begin
            issue(3'(c), 8'h00, 1'b0, SDA_RANDOM, 0);
        end
        issue(CMD_START, 8'h00, 1'b0, SDA_RANDOM, 0);

        // zero length is treated as length one: field extremes, write, read and stop
        write_phase_len(16'd0);
        issue(CMD_WRITE, 8'h00, 1'b0, SDA_LOW, 0);
        issue(CMD_WRITE, 8'hFF, 1'b1, SDA_HIGH, 0);
        // commands on every busy tick, the finishing tick included
        issue(CMD_WRITE, 8'hA5, 1'b0, SDA_RANDOM, 100);
        issue(CMD_READ, 8'h00, 1'b1, SDA_HIGH, 0);
        issue(CMD_READ, 8'hFF, 1'b0, SDA_LOW, 0);
        issue(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM, 50);

        // longest phase, idle ticks only
        write_phase_len(16'hFFFF);
        gap_max = 0;
        issue(CMD_NONE, 8'h00, 1'b0, SDA_RANDOM, 0);
        issue(CMD_RSVD_LAST, 8'hFF, 1'b1, SDA_RANDOM, 0);

        for (int s = 0; s < 7; s++) begin
            write_phase_len(16'(phase_lens[s]));
            gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
            target  = cmds_issued + 4;
            while (cmds_issued < target) begin
                run_transaction(($urandom_range(0, 3) == 0) ? 20 : 0);
                if ($urandom_range(0, 3) == 0) begin
                    drain_results();
                end
            end
        end

        drain_results();
        if (mismatch_count == 0 && beats_in_flight == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
